### hw/rtl/sud_pkg.sv
// Shared types, codes and constants of the swap usage duration predictor.
package sud_pkg;

    localparam int TIME_W = 63;
    localparam int DATA_W = 64;
    localparam int CFG_W  = 40;

    localparam logic [1:0] KIND_ENABLE  = 2'd0;
    localparam logic [1:0] KIND_DISABLE = 2'd1;
    localparam logic [1:0] KIND_PREDICT = 2'd2;
    localparam logic [1:0] KIND_RESTORE = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_TOO_NEW  = 3'd2;
    localparam logic [2:0] ST_ORDER    = 3'd3;
    localparam logic [2:0] ST_NEG_DUR  = 3'd4;

    localparam logic CFG_MERGE = 1'b0;
    localparam logic CFG_WEEK  = 1'b1;

    localparam logic [CFG_W-1:0] MERGE_RESET = 40'd3600000000;
    localparam logic [CFG_W-1:0] WEEK_RESET  = 40'd604800000000;

    typedef struct packed {
        logic [1:0]        kind;
        logic [62:0]       time_us;
        logic [62:0]       entry_start_us;
        logic signed [63:0] entry_duration_us;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic signed [63:0] predicted_us;
        logic              record_valid;
        logic [62:0]       record_start_us;
        logic signed [63:0] record_duration_us;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_RD_NEW, OP_RD_K, OP_LOAD, OP_ENABLE, OP_MISS, OP_DIS,
        OP_RESTORE, OP_PBEGIN, OP_DIV_NW, OP_NW, OP_DOUBLE, OP_DUR, OP_DIV_SW, OP_SW,
        OP_DIV_EW, OP_EW, OP_DOW, OP_DIV_R, OP_REPS, OP_MUL_T, OP_TRI, OP_MUL_W, OP_WT,
        OP_MUL_R, OP_ACC, OP_NEXT, OP_DIV_F, OP_PRED, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       enabled;
        logic       cnt_zero;
        logic       div_busy;
        logic       mul_busy;
        logic       nw_zero;
        logic       ew_take;
        logic       dow_big;
        logic       last_k;
        logic       out_free;
    } dp_status_t;

endpackage

### hw/rtl/swap_usage_duration_predictor.sv
// Top level of the swap usage duration predictor.
// Keeps a ring of HISTORY_DEPTH enabled periods in a RAM and answers one item at a time,
// giving exactly one result item for each input item. A predict item walks every stored
// period through one shared radix-2 divider and one shift-and-add multiplier; a period
// that overlaps more than one week needs one more division and three multiplications.
// With under one week of history a predict item skips the walk and doubles the newest
// duration. The output register holds a finished result until it is taken, and
// configuration writes take effect at once.
module swap_usage_duration_predictor #(
    parameter int HISTORY_DEPTH = 32,
    parameter int NUM_WEEKS     = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sud_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sud_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [39:0]        cfg_data
);

    import sud_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sud_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd     (cmd),
        .status  (status)
    );

    sud_dp #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .NUM_WEEKS    (NUM_WEEKS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

endmodule

### hw/rtl/sud_ram.sv
// Generic single-port-write RAM with one registered read port.
module sud_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/sud_div.sv
// Radix-2 restoring signed divider, 64 bits, truncating quotient and remainder.
module sud_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic [63:0] quot,
    output logic [63:0] rem
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] d_reg, d_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        shifted   = {r_reg, q_reg[63]};
        diff      = shifted - {1'b0, d_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd63;
            r_next    = '0;
            q_next    = dividend[63] ? (64'd0 - dividend) : dividend;
            d_next    = divisor[63] ? (64'd0 - divisor) : divisor;
            negq_next = dividend[63] ^ divisor[63];
            negr_next = dividend[63];
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                r_next = diff[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = shifted[63:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign busy = busy_reg;
    assign quot = negq_reg ? (64'd0 - q_reg) : q_reg;
    assign rem  = negr_reg ? (64'd0 - r_reg) : r_reg;

endmodule

### hw/rtl/sud_mul.sv
// Shift-and-add multiplier, 64 by 64 bits, product kept modulo 2^64.
module sud_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        busy,
    output logic [63:0] prod
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] p_reg, p_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd63;
            a_next    = a;
            b_next    = b;
            p_next    = '0;
        end
        else if (busy_reg)
        begin
            if (a_reg[0])
            begin
                p_next = p_reg + b_reg;
            end
            a_next = {1'b0, a_reg[63:1]};
            b_next = {b_reg[62:0], 1'b0};
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign busy = busy_reg;
    assign prod = p_reg;

endmodule

### hw/rtl/sud_dp.sv
// Datapath: period ring, configuration, arithmetic registers and the output register.
module sud_dp #(
    parameter int HISTORY_DEPTH = 32,
    parameter int NUM_WEEKS     = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sud_pkg::dp_cmd_t    cmd,
    output sud_pkg::dp_status_t status,
    input  sud_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sud_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [39:0]         cfg_data
);

    import sud_pkg::*;

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam int IW     = CW + 1;
    localparam int ENT_W  = TIME_W + DATA_W + 1;
    localparam int SPAN_W = CFG_W + $clog2(NUM_WEEKS + 1);
    localparam logic [IW-1:0] DEPTH_I = IW'(HISTORY_DEPTH);
    localparam logic [63:0]   NW_S    = 64'(NUM_WEEKS);

    op_t op;
    assign op = cmd.op;

    // Control state.
    logic          en_reg, en_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [62:0]   last_reg, last_next;
    logic [39:0]   mw_reg, mw_next;
    logic [39:0]   wk_reg, wk_next;
    logic          out_valid_reg, out_valid_next;

    // Payload.
    logic [1:0]    kind_reg, kind_next;
    logic [62:0]   now_reg, now_next;
    logic [62:0]   rstart_reg, rstart_next;
    logic [63:0]   rdur_reg, rdur_next;
    logic [62:0]   e_start_reg, e_start_next;
    logic [63:0]   e_len_reg, e_len_next;
    logic          e_open_reg, e_open_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] k_reg, k_next;
    logic [63:0]   nw_reg, nw_next;
    logic [63:0]   sw_reg, sw_next;
    logic [63:0]   ew_reg, ew_next;
    logic [63:0]   dur_reg, dur_next;
    logic [63:0]   dow_reg, dow_next;
    logic [63:0]   reps_reg, reps_next;
    logic [63:0]   tri_reg, tri_next;
    logic [63:0]   wt_reg, wt_next;
    logic [63:0]   sum_reg, sum_next;
    logic [63:0]   wsw_reg, wsw_next;
    out_item_t     res_reg, res_next;
    out_item_t     out_data_reg, out_data_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    logic        div_start, div_busy;
    logic [63:0] div_a, div_b, div_q, div_r;
    logic        mul_start, mul_busy;
    logic [63:0] mul_a, mul_b, mul_p;

    logic [39:0]       wlen;
    logic [63:0]       w64;
    logic [SPAN_W-1:0] span;
    logic [63:0]       span64;
    logic [63:0]       now64, es64, mw64;
    logic [63:0]       diff_ns;
    logic [63:0]       dur_c;
    logic [63:0]       dow_c;
    logic [63:0]       keep_end;
    logic [62:0]       miss_start;
    logic [AW-1:0]     newest_idx, oldest_idx, rk_idx, wp_inc;
    logic [IW-1:0]     old_t, rk_t;
    logic [CW-1:0]     cnt_inc;
    logic              push;
    logic [62:0]       push_start;
    logic [63:0]       push_len;
    logic              push_open;
    logic              keep;

    assign wlen    = (wk_reg == '0) ? 40'd1 : wk_reg;
    assign w64     = 64'(wlen);
    assign span    = SPAN_W'(wlen) * SPAN_W'(NUM_WEEKS);
    assign span64  = 64'(span);
    assign now64   = {1'b0, now_reg};
    assign es64    = {1'b0, e_start_reg};
    assign mw64    = 64'(mw_reg);
    assign diff_ns = now64 - es64;
    assign dur_c   = e_open_reg ? diff_ns : e_len_reg;
    assign dow_c   = dur_reg + es64 - (now64 - wsw_reg);
    assign keep_end   = {1'b0, rstart_reg} + rdur_reg;
    assign miss_start = 63'(es64 + mw64);

    assign newest_idx = (wp_reg == '0) ? AW'(HISTORY_DEPTH - 1) : wp_reg - AW'(1);
    assign old_t      = IW'(wp_reg) + DEPTH_I - IW'(cnt_reg);
    assign oldest_idx = (old_t >= DEPTH_I) ? AW'(old_t - DEPTH_I) : AW'(old_t);
    assign rk_t       = IW'(base_reg) + IW'(k_reg);
    assign rk_idx     = (rk_t >= DEPTH_I) ? AW'(rk_t - DEPTH_I) : AW'(rk_t);
    assign wp_inc     = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    assign cnt_inc    = (cnt_reg == CW'(HISTORY_DEPTH)) ? cnt_reg : cnt_reg + CW'(1);

    assign ram_raddr = (op == OP_RD_K) ? rk_idx : newest_idx;

    // Divider and multiplier operand selection.
    always_comb
    begin
        div_start = op inside {OP_DIV_NW, OP_DIV_SW, OP_DIV_EW, OP_DIV_R, OP_DIV_F};
        div_b     = (op == OP_DIV_F) ? nw_reg : w64;
        case (op)
            OP_DIV_EW: div_a = diff_ns - dur_reg;
            OP_DIV_R:  div_a = dow_reg - 64'd1;
            OP_DIV_F:  div_a = sum_reg;
            default:   div_a = diff_ns;
        endcase
        mul_start = op inside {OP_MUL_T, OP_MUL_W, OP_MUL_R};
        case (op)
            OP_MUL_T:
            begin
                // One factor of reps*(reps+1) is even; halve that one first.
                mul_a = reps_reg[0] ? reps_reg : {1'b0, reps_reg[63:1]};
                mul_b = reps_reg[0] ? {1'b0, 63'((reps_reg + 64'd1) >> 1)} : reps_reg + 64'd1;
            end
            OP_MUL_W:
            begin
                mul_a = w64;
                mul_b = tri_reg;
            end
            default:
            begin
                mul_a = reps_reg;
                mul_b = dow_reg;
            end
        endcase
    end

    always_comb
    begin
        en_next        = en_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        mw_next        = mw_reg;
        wk_next        = wk_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        now_next       = now_reg;
        rstart_next    = rstart_reg;
        rdur_next      = rdur_reg;
        e_start_next   = e_start_reg;
        e_len_next     = e_len_reg;
        e_open_next    = e_open_reg;
        base_next      = base_reg;
        k_next         = k_reg;
        nw_next        = nw_reg;
        sw_next        = sw_reg;
        ew_next        = ew_reg;
        dur_next       = dur_reg;
        dow_next       = dow_reg;
        reps_next      = reps_reg;
        tri_next       = tri_reg;
        wt_next        = wt_reg;
        sum_next       = sum_reg;
        wsw_next       = wsw_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        push           = 1'b0;
        push_start     = now_reg;
        push_len       = '0;
        push_open      = 1'b1;
        keep           = 1'b1;
        ram_we         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (op)
            OP_LATCH:
            begin
                kind_next   = in_data.kind;
                now_next    = in_data.time_us;
                rstart_next = in_data.entry_start_us;
                rdur_next   = in_data.entry_duration_us;
                res_next    = '0;
                sum_next    = '0;
            end
            OP_LOAD:
            begin
                e_start_next = ram_rdata[ENT_W-1 -: TIME_W];
                e_len_next   = ram_rdata[DATA_W:1];
                e_open_next  = ram_rdata[0];
            end
            OP_ENABLE:
            begin
                if (!en_reg)
                begin
                    en_next = 1'b1;
                    if (cnt_reg == '0 || $signed(es64) <= $signed(now64 - mw64))
                    begin
                        push = 1'b1;
                    end
                end
            end
            OP_MISS:
            begin
                // A period left closed too long is followed by a synthetic open one.
                if (en_reg && cnt_reg != '0 && !e_open_reg && $signed(diff_ns) >= $signed(mw64))
                begin
                    push         = 1'b1;
                    push_start   = miss_start;
                    e_start_next = miss_start;
                    e_len_next   = '0;
                    e_open_next  = 1'b1;
                end
            end
            OP_DIS:
            begin
                if (en_reg)
                begin
                    en_next = 1'b0;
                    if (cnt_reg != '0)
                    begin
                        if (e_start_reg > now_reg)
                        begin
                            res_next.status = ST_MISMATCH;
                        end
                        else if (e_open_reg)
                        begin
                            ram_we                     = 1'b1;
                            ram_waddr                  = newest_idx;
                            ram_wdata                  = {e_start_reg, diff_ns, 1'b0};
                            res_next.record_valid       = 1'b1;
                            res_next.record_start_us    = e_start_reg;
                            res_next.record_duration_us = diff_ns;
                        end
                    end
                end
            end
            OP_RESTORE:
            begin
                if (rstart_reg > now_reg || rstart_reg < last_reg || rdur_reg[63])
                begin
                    if (rstart_reg > now_reg)
                    begin
                        res_next.status = ST_TOO_NEW;
                    end
                    else if (rstart_reg < last_reg)
                    begin
                        res_next.status = ST_ORDER;
                    end
                    else
                    begin
                        res_next.status = ST_NEG_DUR;
                    end
                    wp_next   = '0;
                    cnt_next  = '0;
                    last_next = '0;
                end
                else
                begin
                    if (now64 >= span64)
                    begin
                        keep = keep_end > (now64 - span64);
                    end
                    push       = keep;
                    push_start = rstart_reg;
                    push_len   = rdur_reg;
                    push_open  = 1'b0;
                    last_next  = rstart_reg;
                end
            end
            OP_PBEGIN:
            begin
                base_next = oldest_idx;
                k_next    = '0;
            end
            OP_NW:
            begin
                nw_next = ($signed(div_q) > $signed(NW_S)) ? NW_S : div_q;
            end
            OP_DOUBLE:
            begin
                res_next.predicted_us = {dur_c[62:0], 1'b0};
            end
            OP_DUR:
            begin
                dur_next = dur_c;
            end
            OP_SW:
            begin
                // Week start times come from the remainder, or from the span when clamped.
                if ($signed(div_q) > $signed(NW_S))
                begin
                    sw_next  = NW_S;
                    wsw_next = span64;
                end
                else
                begin
                    sw_next  = div_q;
                    wsw_next = diff_ns - div_r;
                end
            end
            OP_EW:
            begin
                ew_next = div_q;
            end
            OP_DOW:
            begin
                dow_next = dow_c;
                sum_next = sum_reg + dow_c;
            end
            OP_REPS:
            begin
                reps_next = div_q;
            end
            OP_TRI:
            begin
                tri_next = mul_p;
            end
            OP_WT:
            begin
                wt_next = mul_p;
            end
            OP_ACC:
            begin
                sum_next = sum_reg + mul_p - wt_reg;
            end
            OP_NEXT:
            begin
                k_next = k_reg + AW'(1);
            end
            OP_PRED:
            begin
                res_next.predicted_us = div_q;
            end
            OP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_reg;
            end
            default:
            begin
            end
        endcase

        if (push)
        begin
            ram_we    = 1'b1;
            ram_waddr = wp_reg;
            ram_wdata = {push_start, push_len, push_open};
            wp_next   = wp_inc;
            cnt_next  = cnt_inc;
        end

        if (cfg_we)
        begin
            if (cfg_index == CFG_MERGE)
            begin
                mw_next = cfg_data;
            end
            else
            begin
                wk_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg        <= 1'b0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            last_reg      <= '0;
            mw_reg        <= MERGE_RESET;
            wk_reg        <= WEEK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            en_reg        <= en_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            mw_reg        <= mw_next;
            wk_reg        <= wk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        now_reg      <= now_next;
        rstart_reg   <= rstart_next;
        rdur_reg     <= rdur_next;
        e_start_reg  <= e_start_next;
        e_len_reg    <= e_len_next;
        e_open_reg   <= e_open_next;
        base_reg     <= base_next;
        k_reg        <= k_next;
        nw_reg       <= nw_next;
        sw_reg       <= sw_next;
        ew_reg       <= ew_next;
        dur_reg      <= dur_next;
        dow_reg      <= dow_next;
        reps_reg     <= reps_next;
        tri_reg      <= tri_next;
        wt_reg       <= wt_next;
        sum_reg      <= sum_next;
        wsw_reg      <= wsw_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    sud_ram #(
        .WIDTH(ENT_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    sud_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_a),
        .divisor (div_b),
        .busy    (div_busy),
        .quot    (div_q),
        .rem     (div_r)
    );

    sud_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mul_start),
        .a    (mul_a),
        .b    (mul_b),
        .busy (mul_busy),
        .prod (mul_p)
    );

    assign status.kind     = kind_reg;
    assign status.enabled  = en_reg;
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.div_busy = div_busy;
    assign status.mul_busy = mul_busy;
    assign status.nw_zero  = (nw_reg == '0);
    assign status.ew_take  = ($signed(ew_reg) < $signed(NW_S)) && (sw_reg != ew_reg);
    assign status.dow_big  = $signed(dow_reg) > $signed(w64);
    assign status.last_k   = (CW'(k_reg) + CW'(1)) == cnt_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hw/rtl/sud_ctrl.sv
// Controller: sequences the datapath through each item's steps.
module sud_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output sud_pkg::dp_cmd_t    cmd,
    input  sud_pkg::dp_status_t status
);

    import sud_pkg::*;

    typedef enum logic [30:0] {
        S_IDLE  = 31'h1 << 0,  S_DISP  = 31'h1 << 1,  S_LDN   = 31'h1 << 2,
        S_EVAL  = 31'h1 << 3,  S_AFTER = 31'h1 << 4,  S_RDB   = 31'h1 << 5,
        S_LDB   = 31'h1 << 6,  S_DNW   = 31'h1 << 7,  S_WNW   = 31'h1 << 8,
        S_NWCHK = 31'h1 << 9,  S_LDN2  = 31'h1 << 10, S_DBL   = 31'h1 << 11,
        S_RDK   = 31'h1 << 12, S_LDK   = 31'h1 << 13, S_DUR   = 31'h1 << 14,
        S_DSW   = 31'h1 << 15, S_WSW   = 31'h1 << 16, S_DEW   = 31'h1 << 17,
        S_WEW   = 31'h1 << 18, S_TAKE  = 31'h1 << 19, S_BIG   = 31'h1 << 20,
        S_WR    = 31'h1 << 21, S_MT    = 31'h1 << 22, S_WMT   = 31'h1 << 23,
        S_MW    = 31'h1 << 24, S_WMW   = 31'h1 << 25, S_MR    = 31'h1 << 26,
        S_WMR   = 31'h1 << 27, S_NEXT  = 31'h1 << 28, S_WF    = 31'h1 << 29,
        S_FIN   = 31'h1 << 30
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (status.kind == KIND_RESTORE)
                begin
                    cmd.op     = OP_RESTORE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_RD_NEW;
                    state_next = S_LDN;
                end
            end
            S_LDN:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (status.kind == KIND_ENABLE)
                begin
                    cmd.op     = OP_ENABLE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_MISS;
                    state_next = S_AFTER;
                end
            end
            S_AFTER:
            begin
                if (status.kind == KIND_DISABLE)
                begin
                    cmd.op     = OP_DIS;
                    state_next = S_FIN;
                end
                else if (status.cnt_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_PBEGIN;
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                cmd.op     = OP_RD_K;
                state_next = S_LDB;
            end
            S_LDB:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_DNW;
            end
            S_DNW:
            begin
                cmd.op     = OP_DIV_NW;
                state_next = S_WNW;
            end
            S_WNW:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_NW;
                    state_next = S_NWCHK;
                end
            end
            S_NWCHK:
            begin
                // Under one week of history: double the newest duration.
                if (status.nw_zero)
                begin
                    cmd.op     = OP_RD_NEW;
                    state_next = S_LDN2;
                end
                else
                begin
                    state_next = S_RDK;
                end
            end
            S_LDN2:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_DBL;
            end
            S_DBL:
            begin
                cmd.op     = OP_DOUBLE;
                state_next = S_FIN;
            end
            S_RDK:
            begin
                cmd.op     = OP_RD_K;
                state_next = S_LDK;
            end
            S_LDK:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_DUR;
            end
            S_DUR:
            begin
                cmd.op     = OP_DUR;
                state_next = S_DSW;
            end
            S_DSW:
            begin
                cmd.op     = OP_DIV_SW;
                state_next = S_WSW;
            end
            S_WSW:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_SW;
                    state_next = S_DEW;
                end
            end
            S_DEW:
            begin
                cmd.op     = OP_DIV_EW;
                state_next = S_WEW;
            end
            S_WEW:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_EW;
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                if (status.ew_take)
                begin
                    cmd.op     = OP_DOW;
                    state_next = S_BIG;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_BIG:
            begin
                if (status.dow_big)
                begin
                    cmd.op     = OP_DIV_R;
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_WR:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_REPS;
                    state_next = S_MT;
                end
            end
            S_MT:
            begin
                cmd.op     = OP_MUL_T;
                state_next = S_WMT;
            end
            S_WMT:
            begin
                if (!status.mul_busy)
                begin
                    cmd.op     = OP_TRI;
                    state_next = S_MW;
                end
            end
            S_MW:
            begin
                cmd.op     = OP_MUL_W;
                state_next = S_WMW;
            end
            S_WMW:
            begin
                if (!status.mul_busy)
                begin
                    cmd.op     = OP_WT;
                    state_next = S_MR;
                end
            end
            S_MR:
            begin
                cmd.op     = OP_MUL_R;
                state_next = S_WMR;
            end
            S_WMR:
            begin
                if (!status.mul_busy)
                begin
                    cmd.op     = OP_ACC;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (status.last_k)
                begin
                    cmd.op     = OP_DIV_F;
                    state_next = S_WF;
                end
                else
                begin
                    cmd.op     = OP_NEXT;
                    state_next = S_RDK;
                end
            end
            S_WF:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_PRED;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

### hw/rtl/sud_chk.sv
// Port-level checker for the predictor and its bind to the top level.
module sud_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input sud_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input sud_pkg::out_item_t out_data,
    input logic               cfg_we,
    input logic               cfg_index,
    input logic [39:0]        cfg_data
);

    import sud_pkg::*;

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    // Only one item is in work: an accepted item closes the input at once.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after an item was accepted");

    // A closed period comes only with an ok status, no prediction and a non-negative length.
    a_record: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.record_valid |->
            out_data.status == ST_OK && out_data.predicted_us == '0 &&
            !out_data.record_duration_us[63])
        else $error("malformed record in result item");

    // Without a record the record fields are zero.
    a_no_record: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.record_valid |->
            out_data.record_start_us == '0 && out_data.record_duration_us == '0)
        else $error("record fields set without a record");

endmodule

bind swap_usage_duration_predictor sud_chk u_chk (.*);
